### src/csfd_pkg.sv
// ----------------------------------------------------------------------------
// csfd_pkg
// Shared types and constants of the CAN signal field decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package csfd_pkg;

    localparam int FRAME_BITS_DEF = 64;
    localparam int CFG_IDX_W      = 3;
    localparam int CFG_DATA_W     = 64;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_START_POSITION,
        REG_FIELD_LENGTH,
        REG_INTEL_ORDER,
        REG_SIGNED_MODE,
        REG_SCALE_FACTOR,
        REG_SCALE_OFFSET,
        REG_RESERVED_6,
        REG_RESERVED_7
    } t_cfg_reg;

    typedef struct packed {
        logic [5:0]         start_position;
        logic [6:0]         field_length;
        logic               intel_order;
        logic               signed_mode;
        logic signed [31:0] scale_factor;
        logic signed [63:0] scale_offset;
    } t_cfg;

endpackage

`default_nettype wire

### src/csfd_cfg_regs.sv
// ----------------------------------------------------------------------------
// csfd_cfg_regs
// Configuration register file, written one register per beat.
// ----------------------------------------------------------------------------
`default_nettype none

module csfd_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_valid,
    input  logic [csfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [csfd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_cfg_ready,
    output csfd_pkg::t_cfg                      o_cfg
);

    csfd_pkg::t_cfg r_cfg;
    csfd_pkg::t_cfg n_cfg;

    assign o_cfg_ready = i_rst_n;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            case (i_cfg_index)
                csfd_pkg::REG_START_POSITION: n_cfg.start_position = i_cfg_data[5:0];
                csfd_pkg::REG_FIELD_LENGTH:   n_cfg.field_length   = i_cfg_data[6:0];
                csfd_pkg::REG_INTEL_ORDER:    n_cfg.intel_order    = i_cfg_data[0];
                csfd_pkg::REG_SIGNED_MODE:    n_cfg.signed_mode    = i_cfg_data[0];
                csfd_pkg::REG_SCALE_FACTOR:   n_cfg.scale_factor   = i_cfg_data[31:0];
                csfd_pkg::REG_SCALE_OFFSET:   n_cfg.scale_offset   = i_cfg_data[63:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_position <= 6'd0;
            r_cfg.field_length   <= 7'd8;
            r_cfg.intel_order    <= 1'b1;
            r_cfg.signed_mode    <= 1'b0;
            r_cfg.scale_factor   <= 32'sd65536;
            r_cfg.scale_offset   <= 64'sd0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

### src/csfd_extract.sv
// ----------------------------------------------------------------------------
// csfd_extract
// Two stages: bit walk as one shift with frame bound check, then length
// masking and sign extension of the raw field.
// ----------------------------------------------------------------------------
`default_nettype none

module csfd_extract #(
    parameter int FRAME_BITS = csfd_pkg::FRAME_BITS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic [63:0]         i_frame_data,
    input  csfd_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output logic                o_ok,
    output logic [63:0]         o_raw,
    output logic signed [64:0]  o_value
);

    localparam int CMP_W = ($clog2(FRAME_BITS + 1) > 8) ? $clog2(FRAME_BITS + 1) : 8;
    localparam logic [CMP_W-1:0] FRAME_LIM = CMP_W'(FRAME_BITS);

    logic [6:0]   w_len;
    logic [5:0]   w_start;
    logic         w_len_ok;
    logic [7:0]   w_intel_end;
    logic [5:0]   w_p0;
    logic [7:0]   w_p_last;
    logic [7:0]   w_moto_max;
    logic         w_ok;
    logic [63:0]  w_swapped;
    logic [127:0] w_src;
    logic [7:0]   w_moto_sh;
    logic [6:0]   w_sh;
    logic [127:0] w_shifted;

    logic         r1_valid;
    logic         r1_ok;
    logic [63:0]  r1_bits;

    logic [63:0]  w_mask;
    logic [63:0]  w_raw;
    logic [6:0]   w_top;
    logic         w_neg;
    logic [64:0]  w_value;

    logic         r2_valid;
    logic         r2_ok;
    logic [63:0]  r2_raw;
    logic [64:0]  r2_value;

    assign w_len   = i_cfg.field_length;
    assign w_start = i_cfg.start_position;

    // Motorola order is a straight run in byte-reversed numbering.
    assign w_len_ok    = (w_len != 7'd0) && (w_len <= 7'd64);
    assign w_intel_end = {2'b00, w_start} + {1'b0, w_len};
    assign w_p0        = {w_start[5:3], ~w_start[2:0]};
    assign w_p_last    = {2'b00, w_p0} + {1'b0, w_len} - 8'd1;
    assign w_moto_max  = (w_p_last[7:3] > {2'b00, w_start[5:3]}) ?
                         {w_p_last[7:3], 3'b111} : {2'b00, w_start};

    always_comb begin
        w_ok = 1'b0;
        if (w_len_ok) begin
            if (i_cfg.intel_order) begin
                w_ok = CMP_W'(w_intel_end) <= FRAME_LIM;
            end else begin
                w_ok = CMP_W'(w_moto_max) < FRAME_LIM;
            end
        end
    end

    always_comb begin
        for (int b = 0; b < 8; b++) begin
            w_swapped[8*b +: 8] = i_frame_data[8*(7-b) +: 8];
        end
    end

    assign w_moto_sh = 8'd128 - {2'b00, w_p0} - {1'b0, w_len};
    assign w_src     = i_cfg.intel_order ? {64'd0, i_frame_data} : {w_swapped, 64'd0};
    assign w_sh      = i_cfg.intel_order ? {1'b0, w_start} : w_moto_sh[6:0];
    assign w_shifted = w_src >> w_sh;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_ok   <= w_ok;
        r1_bits <= w_shifted[63:0];
    end

    assign w_mask  = ~({64{1'b1}} << w_len);
    assign w_raw   = r1_bits & w_mask;
    assign w_top   = w_len - 7'd1;
    assign w_neg   = i_cfg.signed_mode && w_raw[w_top[5:0]];
    assign w_value = w_neg ? {1'b1, w_raw | ~w_mask} : {1'b0, w_raw};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r2_ok    <= r1_ok;
        r2_raw   <= r1_ok ? w_raw : 64'd0;
        r2_value <= r1_ok ? w_value : 65'd0;
    end

    assign o_valid = r2_valid;
    assign o_ok    = r2_ok;
    assign o_raw   = r2_raw;
    assign o_value = r2_value;

endmodule

`default_nettype wire

### src/csfd_scale.sv
// ----------------------------------------------------------------------------
// csfd_scale
// Three stages: split signed multiply, offset addition at full width,
// saturation to 64 bits into the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module csfd_scale (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    input  logic                i_ok,
    input  logic [63:0]         i_raw,
    input  logic signed [64:0]  i_value,
    input  csfd_pkg::t_cfg      i_cfg,
    output logic                o_valid,
    output logic signed [63:0]  o_scaled_value,
    output logic [63:0]         o_raw_value,
    output logic                o_decode_ok
);

    localparam logic [63:0] SAT_MAX = {1'b0, {63{1'b1}}};
    localparam logic [63:0] SAT_MIN = {1'b1, {63{1'b0}}};

    logic signed [32:0] w_lo;
    logic signed [32:0] w_hi;
    logic signed [31:0] w_factor;
    logic signed [64:0] w_pl;
    logic signed [64:0] w_ph;

    logic               r3_valid;
    logic               r3_ok;
    logic [63:0]        r3_raw;
    logic [64:0]        r3_pl;
    logic [64:0]        r3_ph;

    logic [63:0]        w_off;
    logic [97:0]        w_sum;

    logic               r4_valid;
    logic               r4_ok;
    logic [63:0]        r4_raw;
    logic [97:0]        r4_sum;

    logic               w_fits;
    logic [63:0]        w_sat;

    logic               r5_valid;
    logic               r5_ok;
    logic [63:0]        r5_raw;
    logic [63:0]        r5_phys;

    assign w_lo     = {1'b0, i_value[31:0]};
    assign w_hi     = i_value[64:32];
    assign w_factor = i_cfg.scale_factor;
    assign w_pl     = 65'(w_lo) * 65'(w_factor);
    assign w_ph     = 65'(w_hi) * 65'(w_factor);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
            r5_valid <= 1'b0;
        end else begin
            r3_valid <= i_valid;
            r4_valid <= r3_valid;
            r5_valid <= r4_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r3_ok  <= i_ok;
        r3_raw <= i_raw;
        r3_pl  <= w_pl;
        r3_ph  <= w_ph;
    end

    assign w_off = i_cfg.scale_offset;
    assign w_sum = {r3_ph[64], r3_ph, 32'd0}
                 + {{33{r3_pl[64]}}, r3_pl}
                 + {{34{w_off[63]}}, w_off};

    always_ff @(posedge i_clk) begin
        r4_ok  <= r3_ok;
        r4_raw <= r3_raw;
        r4_sum <= w_sum;
    end

    assign w_fits = (r4_sum[97:63] == {35{1'b0}}) || (r4_sum[97:63] == {35{1'b1}});
    assign w_sat  = w_fits ? r4_sum[63:0] : (r4_sum[97] ? SAT_MIN : SAT_MAX);

    always_ff @(posedge i_clk) begin
        r5_ok   <= r4_ok;
        r5_raw  <= r4_raw;
        r5_phys <= r4_ok ? w_sat : 64'd0;
    end

    assign o_valid        = r5_valid;
    assign o_decode_ok    = r5_ok;
    assign o_raw_value    = r5_raw;
    assign o_scaled_value = r5_phys;

endmodule

`default_nettype wire

### src/can_signal_field_decoder.sv
// A taken frame passes registers r1, r2 (extract) and r3, r4, r5 (scale) to o_done.
// Throughput: one frame per cycle unless busy; five pipeline stages set the latency.
// The receiver cannot stall; busy and the configuration port are held off only in reset.
// Reset is synchronous: it drops all items in flight and restores default settings.
// ----------------------------------------------------------------------------
// can_signal_field_decoder
// Extracts one configured signal from a 64-bit CAN payload in Intel or
// Motorola order and scales it to a saturated Q47.16 scaled value.
// ----------------------------------------------------------------------------
`default_nettype none

module can_signal_field_decoder #(
    parameter int FRAME_BITS = csfd_pkg::FRAME_BITS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic [63:0]                         i_frame_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [csfd_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [csfd_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output logic                                o_done,
    output logic signed [63:0]                  o_scaled_value,
    output logic [63:0]                         o_raw_value,
    output logic                                o_decode_ok
);

    csfd_pkg::t_cfg     w_cfg;
    logic               w_accept;
    logic               w_ext_valid;
    logic               w_ext_ok;
    logic [63:0]        w_ext_raw;
    logic signed [64:0] w_ext_value;

    assign busy     = !i_rst_n;
    assign w_accept = start && !busy;

    csfd_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (w_cfg)
    );

    csfd_extract #(
        .FRAME_BITS (FRAME_BITS)
    ) u_extract (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_accept),
        .i_frame_data (i_frame_data),
        .i_cfg        (w_cfg),
        .o_valid      (w_ext_valid),
        .o_ok         (w_ext_ok),
        .o_raw        (w_ext_raw),
        .o_value      (w_ext_value)
    );

    csfd_scale u_scale (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_ext_valid),
        .i_ok           (w_ext_ok),
        .i_raw          (w_ext_raw),
        .i_value        (w_ext_value),
        .i_cfg          (w_cfg),
        .o_valid        (o_done),
        .o_scaled_value (o_scaled_value),
        .o_raw_value    (o_raw_value),
        .o_decode_ok    (o_decode_ok)
    );

endmodule

`default_nettype wire

### src/csfd_checker.sv
// ----------------------------------------------------------------------------
// csfd_checker
// Port-level checks of the decoder: fixed latency, one result per beat,
// cleared fields on a failed decode, and an empty pipeline after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module csfd_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 start,
    input logic                 busy,
    input logic                 o_done,
    input logic signed [63:0]   o_scaled_value,
    input logic [63:0]          o_raw_value,
    input logic                 o_decode_ok
);

    a_fail_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_decode_ok) |-> ((o_scaled_value == 64'sd0) && (o_raw_value == 64'd0)))
        else $error("Failed decode carries nonzero result fields.");

    a_beat_returns: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_done)
        else $error("Accepted beat gave no result after five cycles.");

    a_no_spurious: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, 5))
        else $error("Result without a beat accepted five cycles earlier.");

    a_reset_drains: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_done)
        else $error("Result shown right after reset.");

endmodule

bind can_signal_field_decoder csfd_checker u_csfd_checker (.*);

`default_nettype wire

### tb/tb_can_signal_field_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_can_signal_field_decoder
// Self-checking regression for the CAN signal field decoder. A directed table
// covers reset settings, field extremes, bit orders, walks off the frame,
// illegal lengths and saturation, and a long random part follows under
// varying settings and sender gaps. Results are checked against pinned table
// values or a local model of the extraction and fixed-point scaling.
// ----------------------------------------------------------------------------

module tb_can_signal_field_decoder;

    typedef struct packed {
        logic signed [63:0] phys;
        logic [63:0]        raw;
        logic               ok;
    } t_decode_result;

    typedef struct packed {
        bit             load_cfg;
        csfd_pkg::t_cfg cfg;
        logic [63:0]    frame;
        bit             pinned;
        t_decode_result want;
    } t_stim_row;

    localparam logic signed [31:0]  ONE_Q      = 32'sh0001_0000;
    localparam logic signed [63:0]  PHYS_MAX   = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0]  PHYS_MIN   = 64'sh8000_0000_0000_0000;
    localparam logic signed [127:0] WIDE_MAX   = $signed({65'd0, {63{1'b1}}});
    localparam logic signed [127:0] WIDE_MIN   = $signed({{65{1'b1}}, 63'd0});
    localparam logic [63:0]         TOP_BIT    = 64'h8000_0000_0000_0000;
    localparam int                  STALL_LIMIT  = 1000;
    localparam int                  DRAIN_CYCLES = 20;
    localparam int                  SEGMENTS     = 35;
    localparam int                  SEG_FRAMES   = 30;
    localparam int                  DIRECTED_ROWS = 24;

    localparam t_stim_row directed_rows [DIRECTED_ROWS] = '{
        '{1'b0, '0, 64'h0123_4567_89AB_CDA5, 1'b1,
          '{64'sh0000_0000_00A5_0000, 64'hA5, 1'b1}},
        '{1'b1, '{6'd0, 7'd64, 1'b1, 1'b0, ONE_Q, 64'sd0}, '1, 1'b1,
          '{PHYS_MAX, '1, 1'b1}},
        '{1'b1, '{6'd0, 7'd64, 1'b1, 1'b1, ONE_Q, 64'sd0}, '1, 1'b1,
          '{64'shFFFF_FFFF_FFFF_0000, '1, 1'b1}},
        '{1'b1, '{6'd63, 7'd1, 1'b1, 1'b0, ONE_Q, 64'sd0}, TOP_BIT, 1'b1,
          '{64'sh1_0000, 64'h1, 1'b1}},
        '{1'b1, '{6'd63, 7'd2, 1'b1, 1'b0, ONE_Q, 64'sd0}, '1, 1'b1, '0},
        '{1'b1, '{6'd0, 7'd0, 1'b1, 1'b0, ONE_Q, 64'sd0}, '1, 1'b1, '0},
        '{1'b1, '{6'd0, 7'd65, 1'b1, 1'b0, ONE_Q, 64'sd0}, '1, 1'b1, '0},
        '{1'b1, '{6'd0, 7'd127, 1'b0, 1'b1, ONE_Q, 64'sd0}, '1, 1'b1, '0},
        '{1'b1, '{6'd7, 7'd8, 1'b0, 1'b0, ONE_Q, 64'sd0}, 64'h5A, 1'b1,
          '{64'sh5A_0000, 64'h5A, 1'b1}},
        '{1'b1, '{6'd56, 7'd2, 1'b0, 1'b0, ONE_Q, 64'sd0}, '1, 1'b1, '0},
        '{1'b1, '{6'd63, 7'd64, 1'b0, 1'b0, ONE_Q, 64'sd0}, '1, 1'b1, '0},
        '{1'b1, '{6'd7, 7'd64, 1'b0, 1'b0, ONE_Q, 64'sd0},
          64'h0123_4567_89AB_CDEF, 1'b0, '0},
        '{1'b1, '{6'd0, 7'd16, 1'b0, 1'b1, ONE_Q, 64'sd0},
          64'hF00D_CAFE_1357_9BDF, 1'b0, '0},
        '{1'b1, '{6'd0, 7'd64, 1'b1, 1'b0, 32'sh8000_0000, 64'sd0}, '1, 1'b1,
          '{PHYS_MIN, '1, 1'b1}},
        '{1'b1, '{6'd0, 7'd64, 1'b1, 1'b0, 32'sh7FFF_FFFF, PHYS_MAX}, 64'h1, 1'b1,
          '{PHYS_MAX, 64'h1, 1'b1}},
        '{1'b1, '{6'd0, 7'd8, 1'b1, 1'b0, 32'sd0, PHYS_MIN}, 64'hFF, 1'b1,
          '{PHYS_MIN, 64'hFF, 1'b1}},
        '{1'b1, '{6'd0, 7'd8, 1'b1, 1'b1, -32'sd1, 64'sd0}, 64'h80, 1'b1,
          '{64'sh80, 64'h80, 1'b1}},
        '{1'b1, '{6'd5, 7'd1, 1'b1, 1'b1, ONE_Q, 64'sd0}, 64'h20, 1'b1,
          '{64'shFFFF_FFFF_FFFF_0000, 64'h1, 1'b1}},
        '{1'b1, '{6'd0, 7'd64, 1'b1, 1'b1, 32'sh8000_0000, 64'sd0}, TOP_BIT, 1'b1,
          '{PHYS_MAX, TOP_BIT, 1'b1}},
        '{1'b1, '{6'd12, 7'd20, 1'b1, 1'b1, 32'sh0003_8000, 64'shFFFF_FFFF_FFF0_0000},
          64'h9E37_79B9_7F4A_7C15, 1'b0, '0},
        '{1'b1, '{6'd33, 7'd12, 1'b0, 1'b1, 32'shFFFE_0000, 64'sh1234_0000},
          64'hC2B2_AE3D_27D4_EB4F, 1'b0, '0},
        '{1'b1, '{6'd0, 7'd64, 1'b1, 1'b0, 32'sd1, 64'sd0}, TOP_BIT, 1'b1,
          '{PHYS_MAX, TOP_BIT, 1'b1}},
        '{1'b1, '{6'd0, 7'd64, 1'b1, 1'b1, 32'sd1, 64'sd0}, TOP_BIT, 1'b1,
          '{PHYS_MIN, TOP_BIT, 1'b1}},
        '{1'b1, '{6'd0, 7'd64, 1'b1, 1'b0, 32'sd1, -64'sd1}, TOP_BIT, 1'b1,
          '{PHYS_MAX, TOP_BIT, 1'b1}}
    };

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                start;
    logic                                busy;
    logic [63:0]                         i_frame_data;
    logic                                i_cfg_valid;
    logic                                o_cfg_ready;
    logic [csfd_pkg::CFG_IDX_W-1:0]      i_cfg_index;
    logic [csfd_pkg::CFG_DATA_W-1:0]     i_cfg_data;
    logic                                o_done;
    logic signed [63:0]                  o_scaled_value;
    logic [63:0]                         o_raw_value;
    logic                                o_decode_ok;

    csfd_pkg::t_cfg  decoder_cfg;
    t_decode_result  expected_decodes[$];
    bit              pin_on;
    t_decode_result  pin_val;
    int              gap_pct;
    int              error_count;
    int              stall_cycles;

    can_signal_field_decoder dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_frame_data   (i_frame_data),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .o_done         (o_done),
        .o_scaled_value (o_scaled_value),
        .o_raw_value    (o_raw_value),
        .o_decode_ok    (o_decode_ok)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    function automatic bit gather_signal(input logic [63:0] frame, input csfd_pkg::t_cfg c,
                                         output logic [63:0] bits);
        int unsigned len;
        int unsigned idx;
        int unsigned pos;
        bits = '0;
        len  = c.field_length;
        if (len == 0 || len > 64) return 1'b0;
        idx = c.start_position;
        for (int unsigned i = 0; i < len; i++) begin
            if (c.intel_order) idx = c.start_position + i;
            if (idx >= csfd_pkg::FRAME_BITS_DEF) return 1'b0;
            pos = c.intel_order ? i : len - 1 - i;
            if (idx < 64 && frame[idx]) bits[pos] = 1'b1;
            if (!c.intel_order) idx = (idx % 8 == 0) ? idx + 15 : idx - 1;
        end
        return 1'b1;
    endfunction

    function automatic t_decode_result decode_frame(input logic [63:0] frame,
                                                    input csfd_pkg::t_cfg c);
        t_decode_result      r;
        logic [63:0]         bits;
        logic signed [127:0] wide_val;
        logic signed [127:0] wide_fac;
        logic signed [127:0] wide_off;
        logic signed [127:0] total;
        r = '0;
        if (!gather_signal(frame, c, bits)) return r;
        wide_val = {64'd0, bits};
        if (c.signed_mode && bits[c.field_length - 1])
            wide_val = wide_val | ~((128'd1 << c.field_length) - 128'd1);
        wide_fac = {{96{c.scale_factor[31]}}, c.scale_factor};
        wide_off = {{64{c.scale_offset[63]}}, c.scale_offset};
        total    = wide_val * wide_fac + wide_off;
        if (total > WIDE_MAX) begin
            r.phys = PHYS_MAX;
        end else if (total < WIDE_MIN) begin
            r.phys = PHYS_MIN;
        end else begin
            r.phys = total[63:0];
        end
        r.raw = bits;
        r.ok  = 1'b1;
        return r;
    endfunction

    function automatic csfd_pkg::t_cfg random_settings();
        csfd_pkg::t_cfg c;
        logic [63:0]    probe;
        c.intel_order = 1'($urandom_range(1));
        c.signed_mode = 1'($urandom_range(1));
        case ($urandom_range(4))
            0: c.scale_factor = ONE_Q;
            1: c.scale_factor = $urandom;
            2: c.scale_factor = $signed($urandom) >>> $urandom_range(31);
            3: c.scale_factor = $urandom_range(1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
            default: c.scale_factor = -32'sd1;
        endcase
        case ($urandom_range(3))
            0: c.scale_offset = '0;
            1: c.scale_offset = {$urandom, $urandom};
            2: c.scale_offset = $signed({$urandom, $urandom}) >>> $urandom_range(63);
            default: c.scale_offset = $urandom_range(1) ? PHYS_MAX : PHYS_MIN;
        endcase
        if ($urandom_range(11) == 0) begin
            c.field_length = $urandom_range(1) ? 7'd0 : 7'($urandom_range(65, 127));
        end else if ($urandom_range(3) == 0) begin
            c.field_length = 7'd64;
        end else begin
            c.field_length = 7'($urandom_range(1, 64));
        end
        c.start_position = 6'($urandom_range(63));
        if ($urandom_range(7) != 0) begin
            for (int t = 0; t < 16 && !gather_signal(64'd0, c, probe); t++)
                c.start_position = 6'($urandom_range(63));
            if (!gather_signal(64'd0, c, probe))
                c.start_position = c.intel_order ? 6'd0 : 6'd7;
        end
        return c;
    endfunction

    function automatic logic [63:0] random_frame();
        case ($urandom_range(15))
            0: return '0;
            1: return '1;
            2: return 64'd1 << $urandom_range(63);
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic apply_register(input csfd_pkg::t_cfg_reg idx, input logic [63:0] data);
        case (idx)
            csfd_pkg::REG_START_POSITION: decoder_cfg.start_position = data[5:0];
            csfd_pkg::REG_FIELD_LENGTH:   decoder_cfg.field_length   = data[6:0];
            csfd_pkg::REG_INTEL_ORDER:    decoder_cfg.intel_order    = data[0];
            csfd_pkg::REG_SIGNED_MODE:    decoder_cfg.signed_mode    = data[0];
            csfd_pkg::REG_SCALE_FACTOR:   decoder_cfg.scale_factor   = data[31:0];
            csfd_pkg::REG_SCALE_OFFSET:   decoder_cfg.scale_offset   = data;
            default: ;
        endcase
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    endtask

    // A frame beat is taken when start is high and busy is low; results cannot stall.
    always @(posedge i_clk) begin : scoreboard
        t_decode_result want;
        bit             progress;
        progress = 1'b0;
        if (i_cfg_valid && o_cfg_ready) begin
            apply_register(csfd_pkg::t_cfg_reg'(i_cfg_index), i_cfg_data);
            progress = 1'b1;
        end
        if (i_rst_n && start && !busy) begin
            expected_decodes.push_back(pin_on ? pin_val : decode_frame(i_frame_data, decoder_cfg));
            progress = 1'b1;
        end
        if (o_done === 1'b1) begin
            progress = 1'b1;
            if (expected_decodes.size() == 0) begin
                report_mismatch("result with no frame pending, raw", o_raw_value, '0);
            end else begin
                want = expected_decodes.pop_front();
                if (o_scaled_value !== want.phys)
                    report_mismatch("scaled_value", o_scaled_value, want.phys);
                if (o_raw_value !== want.raw)
                    report_mismatch("raw_value", o_raw_value, want.raw);
                if (o_decode_ok !== want.ok)
                    report_mismatch("decode_ok", 64'(o_decode_ok), 64'(want.ok));
            end
        end
        stall_cycles = progress ? 0 : stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("can_signal_field_decoder regression: fail");
            $finish;
        end
    end

    task automatic write_reg(input csfd_pkg::t_cfg_reg idx, input logic [63:0] data);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic load_settings(input csfd_pkg::t_cfg c, input bit junk);
        logic [63:0] fill;
        fill = junk ? {$urandom, $urandom} : 64'd0;
        write_reg(csfd_pkg::REG_START_POSITION, {fill[63:6], c.start_position});
        write_reg(csfd_pkg::REG_FIELD_LENGTH,   {fill[63:7], c.field_length});
        write_reg(csfd_pkg::REG_INTEL_ORDER,    {fill[63:1], c.intel_order});
        write_reg(csfd_pkg::REG_SIGNED_MODE,    {fill[63:1], c.signed_mode});
        write_reg(csfd_pkg::REG_SCALE_FACTOR,   {fill[63:32], c.scale_factor});
        write_reg(csfd_pkg::REG_SCALE_OFFSET,   c.scale_offset);
    endtask

    task automatic send_frame(input logic [63:0] frame, input bit pinned,
                              input t_decode_result want);
        while ($urandom_range(99) < gap_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start        = 1'b1;
        i_frame_data = frame;
        pin_on       = pinned;
        pin_val      = want;
        do @(posedge i_clk); while (busy);
    endtask

    task automatic finish_burst();
        @(negedge i_clk);
        start  = 1'b0;
        pin_on = 1'b0;
        while (expected_decodes.size() != 0) @(negedge i_clk);
    endtask

    initial begin : stimulus
        int gap_phases [4];
        gap_phases   = '{0, 49, 0, 17};
        decoder_cfg  = '{6'd0, 7'd8, 1'b1, 1'b0, ONE_Q, 64'sd0};
        i_rst_n      = 1'b0;
        start        = 1'b0;
        i_frame_data = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = csfd_pkg::REG_START_POSITION;
        i_cfg_data   = '0;
        pin_on       = 1'b0;
        pin_val      = '0;
        gap_pct      = 0;
        error_count  = 0;
        stall_cycles = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed_rows[n]) begin
            if (directed_rows[n].load_cfg) begin
                finish_burst();
                load_settings(directed_rows[n].cfg, 1'b0);
            end
            send_frame(directed_rows[n].frame, directed_rows[n].pinned, directed_rows[n].want);
        end
        finish_burst();
        write_reg(csfd_pkg::REG_RESERVED_6, '1);
        write_reg(csfd_pkg::REG_RESERVED_7, '1);
        send_frame(random_frame(), 1'b0, '0);

        for (int seg = 0; seg < SEGMENTS; seg++) begin
            finish_burst();
            load_settings(random_settings(), 1'($urandom_range(1)));
            gap_pct = gap_phases[seg % 4];
            repeat (SEG_FRAMES) send_frame(random_frame(), 1'b0, '0);
        end
        finish_burst();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (expected_decodes.size() != 0)
            report_mismatch("frames left without result", 64'(expected_decodes.size()), '0);
        if (error_count == 0) begin
            $display("can_signal_field_decoder regression: pass");
        end else begin
            $display("can_signal_field_decoder regression: fail");
        end
        $finish;
    end

endmodule
